>>> sv/afu_pkg.sv
package afu_pkg;

	typedef logic [7:0] gf_byte_t;
	typedef gf_byte_t [3:0] gf_word_t;
	typedef gf_byte_t tbl_t [256];

	localparam logic [3:0] FN_ADD    = 4'd0;
	localparam logic [3:0] FN_MUL    = 4'd1;
	localparam logic [3:0] FN_DIV    = 4'd2;
	localparam logic [3:0] FN_INV    = 4'd3;
	localparam logic [3:0] FN_SBOX   = 4'd4;
	localparam logic [3:0] FN_INVSBOX = 4'd5;
	localparam logic [3:0] FN_ENC    = 4'd6;
	localparam logic [3:0] FN_DEC    = 4'd7;
	localparam logic [3:0] FN_INVMIX = 4'd8;
	localparam logic [3:0] FN_WPROD  = 4'd9;

	localparam logic [8:0] GF_POLY   = 9'h11b;
	localparam gf_byte_t   AFF_FWD   = 8'h63;
	localparam gf_byte_t   AFF_INV   = 8'h05;
	localparam int         INV_EXP   = 254;

	typedef struct packed {
		logic [3:0] func;
		logic [1:0] rot;
	} afu_ctl_t;

	function automatic gf_byte_t gf_mul(input gf_byte_t a, input gf_byte_t b);
		logic [8:0] acc_a;
		gf_byte_t p;
		acc_a = {1'b0, a};
		p = '0;
		for (int i = 0; i < 8; i++) begin
			if (b[i]) begin
				p = p ^ acc_a[7:0];
			end
			acc_a = {acc_a[7:0], 1'b0};
			if (acc_a[8]) begin
				acc_a = acc_a ^ GF_POLY;
			end
		end
		return p;
	endfunction

	function automatic gf_byte_t rotl8(input gf_byte_t x, input int k);
		gf_byte_t r;
		r = x;
		for (int i = 0; i < k; i++) begin
			r = {r[6:0], r[7]};
		end
		return r;
	endfunction

	function automatic tbl_t build_inv();
		tbl_t t;
		gf_byte_t r;
		for (int x = 0; x < 256; x++) begin
			r = 8'd1;
			for (int e = 0; e < INV_EXP; e++) begin
				r = gf_mul(r, x[7:0]);
			end
			t[x] = (x == 0) ? 8'd0 : r;
		end
		return t;
	endfunction

	localparam tbl_t INV_TBL = build_inv();

	function automatic tbl_t build_sbox();
		tbl_t t;
		gf_byte_t v;
		for (int x = 0; x < 256; x++) begin
			v = INV_TBL[x];
			t[x] = v ^ rotl8(v, 1) ^ rotl8(v, 2) ^ rotl8(v, 3) ^ rotl8(v, 4) ^ AFF_FWD;
		end
		return t;
	endfunction

	function automatic tbl_t build_isbox();
		tbl_t t;
		gf_byte_t s;
		gf_byte_t v;
		for (int x = 0; x < 256; x++) begin
			s = x[7:0];
			v = rotl8(s, 1) ^ rotl8(s, 3) ^ rotl8(s, 6) ^ AFF_INV;
			t[x] = INV_TBL[v];
		end
		return t;
	endfunction

	localparam tbl_t SBOX_TBL  = build_sbox();
	localparam tbl_t ISBOX_TBL = build_isbox();

endpackage

>>> sv/afu_in_if.sv
interface afu_in_if;
	logic        valid;
	logic        ready;
	logic [3:0]  func;
	logic [31:0] operand_a;
	logic [31:0] operand_b;

	modport source (output valid, output func, output operand_a, output operand_b,
		input ready);
	modport sink (input valid, input func, input operand_a, input operand_b,
		output ready);
endinterface

>>> sv/afu_out_if.sv
interface afu_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] result;

	modport source (output valid, output result, input ready);
	modport sink (input valid, input result, output ready);
endinterface

>>> sv/afu_lane.sv
module afu_lane (
	input  afu_pkg::gf_word_t a_coef,
	input  afu_pkg::gf_word_t b_coef,
	output afu_pkg::gf_byte_t col
);
	import afu_pkg::*;

	gf_byte_t prod [4];

	always_comb begin
		for (int j = 0; j < 4; j++) begin
			prod[j] = gf_mul(a_coef[j], b_coef[j]);
		end
	end

	assign col = prod[0] ^ prod[1] ^ prod[2] ^ prod[3];
endmodule

>>> sv/afu_merge.sv
module afu_merge (
	input  afu_pkg::afu_ctl_t ctl,
	input  afu_pkg::gf_byte_t val,
	input  afu_pkg::gf_word_t prod,
	output logic [31:0]       result
);
	import afu_pkg::*;

	gf_word_t enc_w;
	gf_word_t dec_w;
	gf_word_t tbl_w;
	gf_word_t rot_w;

	assign enc_w = {gf_mul(val, 8'h03), val, val, gf_mul(val, 8'h02)};
	assign dec_w = {gf_mul(val, 8'h0b), gf_mul(val, 8'h0d), gf_mul(val, 8'h09),
		gf_mul(val, 8'h0e)};
	assign tbl_w = (ctl.func == FN_ENC) ? enc_w : dec_w;

	// rotate left by whole bytes
	always_comb begin
		unique case (ctl.rot)
			2'd0: rot_w = tbl_w;
			2'd1: rot_w = {tbl_w[2], tbl_w[1], tbl_w[0], tbl_w[3]};
			2'd2: rot_w = {tbl_w[1], tbl_w[0], tbl_w[3], tbl_w[2]};
			2'd3: rot_w = {tbl_w[0], tbl_w[3], tbl_w[2], tbl_w[1]};
			default: rot_w = tbl_w;
		endcase
	end

	always_comb begin
		unique case (ctl.func)
			FN_ADD, FN_MUL, FN_DIV, FN_INV, FN_SBOX, FN_INVSBOX: result = {24'd0, val};
			FN_ENC, FN_DEC, FN_INVMIX: result = rot_w;
			FN_WPROD: result = prod;
			default: result = '0;
		endcase
	end
endmodule

>>> sv/aes_field_arithmetic_unit_top.sv
// GF(2^8) arithmetic unit, reduction polynomial 0x11b. Takes one operation per
// cycle unless a full pipeline is held by res.ready, and returns one 32-bit result
// per operation, in order (input register, lane/byte stage, output register).
// Byte ops return the byte zero-extended; table ops return a round-table word
// rotated left by 8 * operand_b[1:0]; the word product uses four lanes, one per
// result byte. Unused func codes return zero. No state, no configuration.
module aes_field_arithmetic_unit_top (
	input  logic clk,
	input  logic arst_n,
	afu_in_if.sink   op,
	afu_out_if.source res
);
	import afu_pkg::*;

	logic        en1, en2, en3;
	logic        valid_s1, valid_s2, valid_s3;
	logic [3:0]  func_s1;
	logic [31:0] a_s1, b_s1;
	afu_ctl_t    ctl_s2;
	gf_byte_t    val_s2;
	gf_word_t    prod_s2;
	logic [31:0] result_s3;

	gf_byte_t    al, bl, val;
	gf_word_t    lane_a [4];
	gf_word_t    b_word;
	gf_word_t    lane_col;
	logic [31:0] merged;

	assign en3 = !valid_s3 || res.ready;
	assign en2 = !valid_s2 || en3;
	assign en1 = !valid_s1 || en2;
	assign op.ready = en1;

	assign res.valid  = valid_s3;
	assign res.result = result_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (en1) valid_s1 <= op.valid;
			if (en2) valid_s2 <= valid_s1;
			if (en3) valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en1 && op.valid) begin
			func_s1 <= op.func;
			a_s1    <= op.operand_a;
			b_s1    <= op.operand_b;
		end
		if (en2 && valid_s1) begin
			ctl_s2  <= '{func: func_s1, rot: b_s1[1:0]};
			val_s2  <= val;
			prod_s2 <= lane_col;
		end
		if (en3 && valid_s2) begin
			result_s3 <= merged;
		end
	end

	// byte path
	assign al = a_s1[7:0];
	assign bl = b_s1[7:0];

	always_comb begin
		unique case (func_s1)
			FN_ADD:               val = al ^ bl;
			FN_MUL:               val = gf_mul(al, bl);
			FN_DIV:               val = gf_mul(al, INV_TBL[bl]);
			FN_INV:               val = INV_TBL[al];
			FN_SBOX, FN_ENC:      val = SBOX_TBL[al];
			FN_INVSBOX, FN_DEC:   val = ISBOX_TBL[al];
			FN_INVMIX:            val = al;
			default:              val = '0;
		endcase
	end

	// word product lanes, lane k sees a[(k - j) mod 4] against b[j]
	assign b_word = b_s1;

	for (genvar k = 0; k < 4; k++) begin : g_lane
		for (genvar j = 0; j < 4; j++) begin : g_coef
			assign lane_a[k][j] = a_s1[8 * ((k - j) & 3) +: 8];
		end
		afu_lane u_lane (
			.a_coef (lane_a[k]),
			.b_coef (b_word),
			.col    (lane_col[k])
		);
	end

	afu_merge u_merge (
		.ctl    (ctl_s2),
		.val    (val_s2),
		.prod   (prod_s2),
		.result (merged)
	);

	a_in_to_s1: assert property (@(posedge clk) disable iff (!arst_n)
		op.valid && op.ready |=> valid_s1)
		else $error("accepted beat did not reach stage 1");

	a_ready_full: assert property (@(posedge clk) disable iff (!arst_n)
		!op.ready |-> valid_s1 && valid_s2 && valid_s3 && !res.ready)
		else $error("input stalled with room in the pipeline");

	a_s2_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && en3 |=> res.valid)
		else $error("stage 2 beat lost on the way out");

	a_unused_zero: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && en3 && ctl_s2.func > FN_WPROD |=> res.result == '0)
		else $error("unused func code gave a nonzero result");
endmodule
